>>> sv/spf_pkg.sv
// Shared types and constants for the smallest prime factor sieve.
package spf_pkg;

	localparam int LIM_W = 17;
	localparam int ENT_W = 16;
	localparam int I_W   = 9;
	localparam int MAX_DEPTH = 65536;

	localparam logic OP_BUILD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_BUILT = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RD_Q = 2'd0,
		RD_I = 2'd1,
		RD_J = 2'd2
	} rd_src_t;

	typedef enum logic {
		WR_FILL = 1'b0,
		WR_MARK = 1'b1
	} wr_src_t;

	typedef struct packed {
		logic    idx_clr;
		logic    idx_inc;
		logic    i_init;
		logic    i_inc;
		logic    j_init;
		logic    j_inc;
		logic    rd_en;
		rd_src_t rd_src;
		logic    wr_en;
		wr_src_t wr_src;
		logic    q_load;
		logic    out_load;
		logic    out_from_ram;
		status_t out_status;
	} cmd_t;

	typedef struct packed {
		logic fill_done;
		logic sieve_done;
		logic mark_done;
		logic entry_eq_i;
		logic entry_eq_j;
		logic q_in_range;
	} sts_t;

endpackage

>>> sv/smallest_prime_factor_sieve.sv
// Top level of the smallest prime factor sieve.
// Query: table read at the accepting edge, then S_QOUT loads the output register; a new
// request is taken only back in S_IDLE. Build: fill entries below L with their own index,
// mark the multiples of each prime i with i*i < L, load a result (L = effective limit).
// Input stalls during a build or query and while a result waits with out_stall high.
// Reset: limit returns to the table depth, built flag clears, table contents are undefined.
module smallest_prime_factor_sieve
	import spf_pkg::*;
#(
	parameter int TABLE_SIZE = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             opcode,
	input  logic [15:0]      query_value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [15:0]      factor,
	output logic [1:0]       status,
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata
);

	localparam int DEPTH = (TABLE_SIZE > MAX_DEPTH) ? MAX_DEPTH : TABLE_SIZE;

	cmd_t cmd;
	sts_t sts;

	spf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_we   (cfg_we),
		.sts      (sts),
		.cmd      (cmd)
	);

	spf_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.query_value(query_value),
		.cmd        (cmd),
		.sts        (sts),
		.factor     (factor),
		.status     (status)
	);

endmodule

>>> sv/spf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/spf_datapath.sv
// Sieve datapath: limit register, walk counters, table RAM and result register.
module spf_datapath
	import spf_pkg::*;
#(
	parameter int DEPTH = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata,
	input  logic [15:0]      query_value,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic [15:0]      factor,
	output logic [1:0]       status
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(DEPTH);

	logic [LIM_W-1:0] lim_q;
	logic [LIM_W-1:0] idx_q;
	logic [I_W-1:0]   i_q;
	logic [LIM_W-1:0] j_q;
	logic [15:0]      q_q;
	logic [15:0]      factor_q;
	status_t          status_q;

	logic [2*I_W-1:0] i_sq;
	logic [LIM_W-1:0] i_ext;
	logic [ENT_W-1:0] rd_data;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [ENT_W-1:0] wr_data;

	assign i_sq  = {{I_W{1'b0}}, i_q} * {{I_W{1'b0}}, i_q};
	assign i_ext = {{(LIM_W-I_W){1'b0}}, i_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= DEPTH_LIM;
		end else if (cfg_we) begin
			lim_q <= (cfg_wdata > DEPTH_LIM) ? DEPTH_LIM : cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + LIM_W'(1);
		end
		if (cmd.i_init) begin
			i_q <= I_W'(2);
		end else if (cmd.i_inc) begin
			i_q <= i_q + I_W'(1);
		end
		if (cmd.j_init) begin
			j_q <= i_sq[LIM_W-1:0];
		end else if (cmd.j_inc) begin
			j_q <= j_q + i_ext;
		end
		if (cmd.q_load) begin
			q_q <= query_value;
		end
		if (cmd.out_load) begin
			factor_q <= cmd.out_from_ram ? rd_data : 16'd0;
			status_q <= cmd.out_status;
		end
	end

	always_comb begin
		case (cmd.rd_src)
			RD_Q:    rd_addr = query_value[AW-1:0];
			RD_I:    rd_addr = i_ext[AW-1:0];
			RD_J:    rd_addr = j_q[AW-1:0];
			default: rd_addr = query_value[AW-1:0];
		endcase
	end

	always_comb begin
		case (cmd.wr_src)
			WR_FILL: begin
				wr_addr = idx_q[AW-1:0];
				wr_data = idx_q[ENT_W-1:0];
			end
			WR_MARK: begin
				wr_addr = j_q[AW-1:0];
				wr_data = {{(ENT_W-I_W){1'b0}}, i_q};
			end
			default: begin
				wr_addr = idx_q[AW-1:0];
				wr_data = idx_q[ENT_W-1:0];
			end
		endcase
	end

	spf_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign sts.fill_done  = (idx_q >= lim_q);
	assign sts.sieve_done = (i_sq >= {1'b0, lim_q});
	assign sts.mark_done  = (j_q >= lim_q);
	assign sts.entry_eq_i = (rd_data == {{(ENT_W-I_W){1'b0}}, i_q});
	assign sts.entry_eq_j = (rd_data == j_q[ENT_W-1:0]);
	assign sts.q_in_range = ({1'b0, q_q} < lim_q);

	assign factor = factor_q;
	assign status = status_q;

endmodule

>>> sv/spf_ctrl.sv
// Sieve controller: handshakes, build sequencing and query sequencing.
module spf_ctrl
	import spf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic opcode,
	output logic out_valid,
	input  logic out_stall,
	input  logic cfg_we,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_FILL      = 7'b0000010,
		S_PRIME_RD  = 7'b0000100,
		S_PRIME_CHK = 7'b0001000,
		S_MARK_RD   = 7'b0010000,
		S_MARK_CHK  = 7'b0100000,
		S_QOUT      = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   built_q;
	logic   out_valid_q;
	logic   accept;
	logic   build_done;

	assign in_stall = !((state_q == S_IDLE) && (!out_valid_q || !out_stall));
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd        = '0;
		cmd.rd_src = RD_Q;
		cmd.wr_src = WR_FILL;
		cmd.out_status = ST_OK;
		build_done = 1'b0;
		state_nxt  = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_BUILD) begin
						cmd.idx_clr = 1'b1;
						state_nxt   = S_FILL;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_src = RD_Q;
						cmd.q_load = 1'b1;
						state_nxt  = S_QOUT;
					end
				end
			end
			S_QOUT: begin
				cmd.out_load = 1'b1;
				if (!built_q) begin
					cmd.out_status = ST_NOT_BUILT;
				end else if (!sts.q_in_range) begin
					cmd.out_status = ST_RANGE;
				end else begin
					cmd.out_from_ram = 1'b1;
				end
				state_nxt = S_IDLE;
			end
			S_FILL: begin
				if (sts.fill_done) begin
					cmd.i_init = 1'b1;
					state_nxt  = S_PRIME_RD;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_src  = WR_FILL;
					cmd.idx_inc = 1'b1;
				end
			end
			S_PRIME_RD: begin
				if (sts.sieve_done) begin
					cmd.out_load = 1'b1;
					build_done   = 1'b1;
					state_nxt    = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RD_I;
					state_nxt  = S_PRIME_CHK;
				end
			end
			S_PRIME_CHK: begin
				if (sts.entry_eq_i) begin
					cmd.j_init = 1'b1;
					state_nxt  = S_MARK_RD;
				end else begin
					cmd.i_inc = 1'b1;
					state_nxt = S_PRIME_RD;
				end
			end
			S_MARK_RD: begin
				if (sts.mark_done) begin
					cmd.i_inc = 1'b1;
					state_nxt = S_PRIME_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RD_J;
					state_nxt  = S_MARK_CHK;
				end
			end
			S_MARK_CHK: begin
				if (sts.entry_eq_j) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_src = WR_MARK;
				end
				cmd.j_inc = 1'b1;
				state_nxt = S_MARK_RD;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			built_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				built_q <= 1'b0;
			end else if (build_done) begin
				built_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
